FILE: rtl/sfr_pkg.sv
`timescale 1ns / 1ps

package sfr_pkg;

    localparam int MAX_PATTERN_DEF = 8;
    localparam int MAX_REPLACE_DEF = 8;
    localparam int CFG_IDX_W       = 4;
    localparam int CFG_DATA_W      = 64;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MATCH_PATTERN  = 4'd0,
        REG_MATCH_LENGTH   = 4'd1,
        REG_REPLACE_TEXT   = 4'd2,
        REG_REPLACE_LENGTH = 4'd3
    } t_cfg_reg;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } t_in_beat;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       out_last;
    } t_out_beat;

    typedef struct packed {
        logic       wr;
        logic       shift;
        logic [7:0] data;
    } t_cell_ctl;

    // byte k of a 64-bit register, zero past the register
    function automatic logic [7:0] byte_of(input logic [63:0] word, input logic [3:0] k);
        logic [7:0] b;
        b = 8'h00;
        if (!k[3]) begin
            b = word[{k[2:0], 3'b000} +: 8];
        end
        return b;
    endfunction

endpackage

FILE: rtl/sfr_cell.sv
`timescale 1ns / 1ps

module sfr_cell (
    input  logic              i_clk,
    input  sfr_pkg::t_cell_ctl i_ctl,
    input  logic              i_sel,
    input  logic [7:0]        i_next,
    input  logic [7:0]        i_pat,
    input  logic              i_used,
    output logic [7:0]        o_byte,
    output logic              o_ok
);

    logic [7:0] r_byte;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr && i_sel) begin
            r_byte <= i_ctl.data;
        end else if (i_ctl.shift) begin
            r_byte <= i_next;
        end
    end

    assign o_byte = r_byte;
    assign o_ok   = !i_used || (r_byte == i_pat);

endmodule

FILE: rtl/stream_find_and_replace_core.sv
`timescale 1ns / 1ps

// Streaming find and replace, one byte per input beat.
// Channels: input beats (byte, last flag) on i_in_valid/o_in_ready; result
// beats (byte, byte_valid, last flag) on o_out_valid/i_out_ready; register
// writes on i_cfg_valid/o_cfg_ready with an index and 64-bit data, always
// ready. Write registers only while the block is idle.
// Pending bytes sit in a row of cells, one byte each, compared in parallel
// against the pattern; a miss shifts the row by one toward the output.
// The compare state takes each accepted input beat; a result beat that it makes is
// registered into the output register, and replacement and flushed bytes follow
// from the replace and flush states. Per input beat the steps are accept, then
// compare (which can emit one result beat), then one result beat per replacement
// byte on a match and one per flushed byte on a last beat, as the single sequencer
// emits one result beat per cycle into the output register while it is not stalled.
// Reset: window emptied, registers at their reset values (pattern 0, match
// length 1, replacement empty). A stall on the output holds the output register
// and the sequencer in its compare, replace and flush states; no input beat is
// taken until the current one's results have all moved into the output register.
module stream_find_and_replace_core #(
    parameter int MAX_PATTERN = sfr_pkg::MAX_PATTERN_DEF,
    parameter int MAX_REPLACE = sfr_pkg::MAX_REPLACE_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  sfr_pkg::t_in_beat             i_in,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output sfr_pkg::t_out_beat            o_out,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [sfr_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [sfr_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    localparam int FILL_W = $clog2(MAX_PATTERN + 1);
    localparam int RLEN_W = $clog2(MAX_REPLACE + 1);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_EVAL  = 4'b0010,
        ST_REPL  = 4'b0100,
        ST_FLUSH = 4'b1000
    } t_state;

    t_state              r_state, n_state;
    logic [FILL_W-1:0]   r_fill, n_fill;
    logic [RLEN_W-1:0]   r_cnt, n_cnt;
    logic                r_last;
    logic [63:0]         r_pattern, r_replace;
    logic [3:0]          r_mlen, r_rlen;
    logic                r_out_valid;
    sfr_pkg::t_out_beat  r_out, n_beat;

    logic [FILL_W-1:0]   len_eff, fill_eff;
    logic [RLEN_W-1:0]   rlen_eff;
    logic                in_fire, cfg_fire, slot, emit, hit;
    sfr_pkg::t_cell_ctl  cell_ctl;
    logic [7:0]          win [MAX_PATTERN];
    logic [MAX_PATTERN-1:0] cell_ok;

    always_comb begin
        if (r_mlen == 4'd0) begin
            len_eff = FILL_W'(1);
        end else if ({1'b0, r_mlen} > 5'(MAX_PATTERN)) begin
            len_eff = FILL_W'(MAX_PATTERN);
        end else begin
            len_eff = FILL_W'(r_mlen);
        end
        if ({1'b0, r_rlen} > 5'(MAX_REPLACE)) begin
            rlen_eff = RLEN_W'(MAX_REPLACE);
        end else begin
            rlen_eff = RLEN_W'(r_rlen);
        end
    end

    assign fill_eff    = (r_fill >= len_eff) ? '0 : r_fill;
    assign o_in_ready  = (r_state == ST_IDLE);
    assign in_fire     = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;
    assign cfg_fire    = i_cfg_valid && o_cfg_ready;
    assign slot        = !r_out_valid || i_out_ready;
    assign hit         = &cell_ok;

    genvar gi;
    generate
        for (gi = 0; gi < MAX_PATTERN; gi++) begin : g_cell
            logic [7:0] next_byte;
            if (gi == MAX_PATTERN - 1) begin : g_end
                assign next_byte = 8'h00;
            end else begin : g_mid
                assign next_byte = win[gi+1];
            end
            sfr_cell u_cell (
                .i_clk  (i_clk),
                .i_ctl  (cell_ctl),
                .i_sel  (fill_eff == FILL_W'(gi)),
                .i_next (next_byte),
                .i_pat  (sfr_pkg::byte_of(r_pattern, 4'(gi))),
                .i_used (FILL_W'(gi) < len_eff),
                .o_byte (win[gi]),
                .o_ok   (cell_ok[gi])
            );
        end
    endgenerate

    always_comb begin
        n_state        = r_state;
        n_fill         = r_fill;
        n_cnt          = r_cnt;
        emit           = 1'b0;
        n_beat         = '0;
        cell_ctl.wr    = 1'b0;
        cell_ctl.shift = 1'b0;
        cell_ctl.data  = i_in.in_byte;
        unique case (r_state)
            ST_IDLE: begin
                if (in_fire) begin
                    cell_ctl.wr = 1'b1;
                    n_fill      = fill_eff + 1'b1;
                    n_state     = ST_EVAL;
                end
            end
            ST_EVAL: begin
                if (slot) begin
                    if (r_fill == len_eff) begin
                        if (hit) begin
                            n_fill = '0;
                            if (rlen_eff != '0) begin
                                n_cnt   = '0;
                                n_state = ST_REPL;
                            end else begin
                                // deleted match on the last beat: end marker only
                                emit            = r_last;
                                n_beat.out_last = 1'b1;
                                n_state         = ST_IDLE;
                            end
                        end else begin
                            emit              = 1'b1;
                            n_beat.out_byte   = win[0];
                            n_beat.byte_valid = 1'b1;
                            n_beat.out_last   = r_last && (len_eff == FILL_W'(1));
                            cell_ctl.shift    = 1'b1;
                            n_fill            = r_fill - 1'b1;
                            n_state = (r_last && len_eff != FILL_W'(1)) ? ST_FLUSH : ST_IDLE;
                        end
                    end else begin
                        n_state = r_last ? ST_FLUSH : ST_IDLE;
                    end
                end
            end
            ST_REPL: begin
                if (slot) begin
                    emit              = 1'b1;
                    n_beat.out_byte   = sfr_pkg::byte_of(r_replace, 4'(r_cnt));
                    n_beat.byte_valid = 1'b1;
                    n_beat.out_last   = r_last && (r_cnt == rlen_eff - 1'b1);
                    if (r_cnt == rlen_eff - 1'b1) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_cnt = r_cnt + 1'b1;
                    end
                end
            end
            ST_FLUSH: begin
                if (slot) begin
                    emit              = 1'b1;
                    n_beat.out_byte   = win[0];
                    n_beat.byte_valid = 1'b1;
                    n_beat.out_last   = (r_fill == FILL_W'(1));
                    cell_ctl.shift    = 1'b1;
                    n_fill            = r_fill - 1'b1;
                    if (r_fill == FILL_W'(1)) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_fill      <= '0;
            r_cnt       <= '0;
            r_last      <= 1'b0;
            r_pattern   <= '0;
            r_mlen      <= 4'd1;
            r_replace   <= '0;
            r_rlen      <= 4'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fill  <= (cfg_fire && i_cfg_index == sfr_pkg::REG_MATCH_LENGTH) ? '0 : n_fill;
            r_cnt   <= n_cnt;
            if (in_fire) begin
                r_last <= i_in.in_last;
            end
            if (cfg_fire) begin
                unique case (i_cfg_index)
                    sfr_pkg::REG_MATCH_PATTERN:  r_pattern <= i_cfg_data;
                    sfr_pkg::REG_MATCH_LENGTH:   r_mlen    <= i_cfg_data[3:0];
                    sfr_pkg::REG_REPLACE_TEXT:   r_replace <= i_cfg_data;
                    sfr_pkg::REG_REPLACE_LENGTH: r_rlen    <= i_cfg_data[3:0];
                    default: ;
                endcase
            end
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out <= n_beat;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

`ifndef SYNTHESIS
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_IDLE |-> r_fill < len_eff)
        else $error("window fill not below match length while idle");

    a_repl_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_REPL |-> r_fill == '0)
        else $error("window not empty during replacement");

    a_flush_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_FLUSH |-> r_fill != '0)
        else $error("flush with empty window");

    a_marker_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out.byte_valid |-> o_out.out_last && o_out.out_byte == 8'h00)
        else $error("end marker beat malformed");
`endif

endmodule
